// ===== design/tdq_pkg.sv =====
// Shared types and constants for the timer deadline queue.
// No dependencies; imported by tdq_cell, timer_deadline_queue and the testbench.
package tdq_pkg;

  localparam int DL_W = 32;
  localparam int ID_W = 8;
  localparam int DELAY_W = 22;
  localparam int KIND_W = 2;
  localparam int QUEUE_DEPTH_DEF = 16;

  localparam logic OP_ADD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [KIND_W-1:0] KIND_ACCEPTED = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FULL = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EXPIRED = 2'd2;

  localparam logic [DL_W-1:0] DL_SAT = {DL_W{1'b1}};

  typedef logic [DL_W-1:0] deadline_t;
  typedef logic [ID_W-1:0] timer_id_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic      ins;
    logic      pop;
    deadline_t new_dl;
    timer_id_t new_id;
  } cell_ctl_t;

endpackage

// ===== design/tdq_cell.sv =====
// One slot of the sorted timer chain: holds a deadline and id, shifts
// toward the tail on insert and toward the head on pop. Uses tdq_pkg.
module tdq_cell (
  input  logic               clk,
  input  tdq_pkg::cell_ctl_t ctl,
  input  logic               occupied,
  input  logic               at_tail,
  input  logic               prev_shift,
  input  tdq_pkg::deadline_t prev_dl,
  input  tdq_pkg::timer_id_t prev_id,
  input  tdq_pkg::deadline_t next_dl,
  input  tdq_pkg::timer_id_t next_id,
  output logic               shift,
  output tdq_pkg::deadline_t dl,
  output tdq_pkg::timer_id_t id
);
  import tdq_pkg::*;

  deadline_t dl_r, dl_nxt;
  timer_id_t id_r, id_nxt;

  // strictly later deadlines move back; equal ones stay ahead of the new timer
  assign shift = occupied && (dl_r > ctl.new_dl);

  always_comb begin
    dl_nxt = dl_r;
    id_nxt = id_r;
    if (ctl.ins) begin
      if (prev_shift) begin
        dl_nxt = prev_dl;
        id_nxt = prev_id;
      end else if (shift || at_tail) begin
        dl_nxt = ctl.new_dl;
        id_nxt = ctl.new_id;
      end
    end else if (ctl.pop) begin
      dl_nxt = next_dl;
      id_nxt = next_id;
    end
  end

  always_ff @(posedge clk) begin
    dl_r <= dl_nxt;
    id_r <= id_nxt;
  end

  assign dl = dl_r;
  assign id = id_r;

endmodule

// ===== design/timer_deadline_queue.sv =====
// Timer deadline queue: sorted chain of tdq_cell slots plus a sequencer.
// After the accept, a result is registered into out_valid through the deadline-add and apply states.
// A new request is taken only once the accept/add/apply sequencer is idle again;
// an apply waits while the output register still holds an untaken result.
// Reset clears the timer count, elapsed count, sequencer and output valid;
// slot contents are not cleared and are only read below the count.
module timer_deadline_queue #(
  parameter int QUEUE_DEPTH = tdq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_operation,
  input  tdq_pkg::timer_id_t          in_timer_id,
  input  logic [tdq_pkg::DELAY_W-1:0] in_delay_ms,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [tdq_pkg::KIND_W-1:0]  out_event_kind,
  output tdq_pkg::timer_id_t          out_event_id
);
  import tdq_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CALC = 2'd1;
  localparam logic [1:0] ST_APPLY = 2'd2;

  logic [1:0]         state_r, state_nxt;
  logic               op_r;
  timer_id_t          id_r;
  logic [DELAY_W-1:0] delay_r;
  deadline_t          new_dl_r, new_dl_nxt;
  deadline_t          elapsed_r, elapsed_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [KIND_W-1:0]  out_kind_r, out_kind_nxt;
  timer_id_t          out_id_r, out_id_nxt;

  cell_ctl_t  ctl;
  deadline_t  dl_w [QUEUE_DEPTH];
  timer_id_t  id_w [QUEUE_DEPTH];
  logic       shift_w [QUEUE_DEPTH];

  logic       is_full, is_empty, out_free, head_due;
  deadline_t  base_elapsed;
  logic [DL_W:0] dl_sum;

  assign is_full  = (count_r == CNT_W'(QUEUE_DEPTH));
  assign is_empty = (count_r == '0);
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_IDLE);

  assign base_elapsed = is_empty ? '0 : elapsed_r;
  assign dl_sum = {1'b0, base_elapsed} + (DL_W + 1)'(delay_r);
  assign head_due = !is_empty && (dl_w[0] <= elapsed_r);

  always_comb begin
    state_nxt     = state_r;
    new_dl_nxt    = new_dl_r;
    elapsed_nxt   = elapsed_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_kind_nxt  = out_kind_r;
    out_id_nxt    = out_id_r;
    ctl.ins       = 1'b0;
    ctl.pop       = 1'b0;
    ctl.new_dl    = new_dl_r;
    ctl.new_id    = id_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_CALC;
      end
      ST_CALC: begin
        new_dl_nxt = dl_sum[DL_W] ? DL_SAT : dl_sum[DL_W-1:0];
        if (op_r == OP_ADD) begin
          if (!is_full && is_empty) elapsed_nxt = '0;
        end else if (!is_empty && elapsed_r != DL_SAT) begin
          elapsed_nxt = elapsed_r + DL_W'(1);
        end
        state_nxt = ST_APPLY;
      end
      ST_APPLY: begin
        if (op_r == OP_TICK && !head_due) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt = ST_IDLE;
          if (op_r == OP_ADD) begin
            out_id_nxt = id_r;
            if (is_full) begin
              out_kind_nxt = KIND_FULL;
            end else begin
              out_kind_nxt = KIND_ACCEPTED;
              ctl.ins = 1'b1;
              count_nxt = count_r + CNT_W'(1);
            end
          end else begin
            out_kind_nxt = KIND_EXPIRED;
            out_id_nxt = id_w[0];
            ctl.pop = 1'b1;
            count_nxt = count_r - CNT_W'(1);
            if (count_r == CNT_W'(1)) elapsed_nxt = '0;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      elapsed_r   <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      elapsed_r   <= elapsed_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r    <= in_operation;
      id_r    <= in_timer_id;
      delay_r <= in_delay_ms;
    end
    new_dl_r   <= new_dl_nxt;
    out_kind_r <= out_kind_nxt;
    out_id_r   <= out_id_nxt;
  end

  for (genvar gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
    logic      prev_shift;
    deadline_t prev_dl, next_dl;
    timer_id_t prev_id, next_id;
    if (gi == 0) begin : g_head
      assign prev_shift = 1'b0;
      assign prev_dl = '0;
      assign prev_id = '0;
    end else begin : g_mid
      assign prev_shift = shift_w[gi-1];
      assign prev_dl = dl_w[gi-1];
      assign prev_id = id_w[gi-1];
    end
    if (gi == QUEUE_DEPTH - 1) begin : g_tail
      assign next_dl = '0;
      assign next_id = '0;
    end else begin : g_body
      assign next_dl = dl_w[gi+1];
      assign next_id = id_w[gi+1];
    end
    tdq_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .occupied   (count_r > CNT_W'(gi)),
      .at_tail    (count_r == CNT_W'(gi)),
      .prev_shift (prev_shift),
      .prev_dl    (prev_dl),
      .prev_id    (prev_id),
      .next_dl    (next_dl),
      .next_id    (next_id),
      .shift      (shift_w[gi]),
      .dl         (dl_w[gi]),
      .id         (id_w[gi])
    );
  end

  assign out_valid      = out_valid_r;
  assign out_event_kind = out_kind_r;
  assign out_event_id   = out_id_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("timer count exceeds queue depth");

  a_idle_elapsed: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (elapsed_r == '0))
    else $error("elapsed count running with empty queue");

  a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r >= CNT_W'(2)) |-> (dl_w[0] <= dl_w[1]))
    else $error("queue head out of deadline order");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.pop |-> !is_empty)
    else $error("expire request with empty queue");

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for timer_deadline_queue: directed table, then random requests.
// Depends on tdq_pkg and the timer_deadline_queue RTL; results are checked
// against a sorted-list model of the timer queue kept here.
module testbench;
  import tdq_pkg::*;

  localparam int DEPTH = QUEUE_DEPTH_DEF;
  localparam int N_RANDOM = 480;
  localparam int N_TAIL = 60;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT = 300000;
  localparam int N_ROWS = 24;
  localparam logic [DELAY_W-1:0] DELAY_MAX = {DELAY_W{1'b1}};

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    timer_id_t         id;
  } timer_event_t;

  typedef struct packed {
    logic               op;
    timer_id_t          id;
    logic [DELAY_W-1:0] delay;
    logic               typed;
    logic               has_event;
    logic [KIND_W-1:0]  kind;
    timer_id_t          event_id;
  } dir_row_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic               in_operation;
  timer_id_t          in_timer_id;
  logic [DELAY_W-1:0] in_delay_ms;
  logic               out_valid;
  logic               out_ready;
  logic [KIND_W-1:0]  out_event_kind;
  timer_id_t          out_event_id;

  // model of the timer list
  deadline_t list_dl [DEPTH];
  timer_id_t list_id [DEPTH];
  int        list_len;
  deadline_t ms_count;
  bit        running;

  timer_event_t pending_events[$];
  dir_row_t     dir_rows [N_ROWS];

  int  errors;
  int  n_requests;
  int  n_accepted;
  int  n_full;
  int  n_expired;
  int  cycle_count;
  bit  no_idle;

  timer_deadline_queue #(.QUEUE_DEPTH(DEPTH)) u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_operation   (in_operation),
    .in_timer_id    (in_timer_id),
    .in_delay_ms    (in_delay_ms),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_event_kind (out_event_kind),
    .out_event_id   (out_event_id)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic deadline_t sat_add(input deadline_t a, input deadline_t b);
    logic [DL_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[DL_W] ? DL_SAT : sum[DL_W-1:0];
  endfunction

  // Advance the timer list by one request; reports the event it causes, if any.
  function automatic void predict_event(input logic op, input timer_id_t id,
                                        input logic [DELAY_W-1:0] delay,
                                        output bit has_event, output timer_event_t ev);
    deadline_t dl;
    int        pos;
    has_event = 1'b0;
    ev = '0;
    if (op == OP_ADD) begin
      has_event = 1'b1;
      ev.id = id;
      if (list_len >= DEPTH) begin
        ev.kind = KIND_FULL;
        return;
      end
      if (!running || list_len == 0) begin
        ms_count = '0;
        running = 1'b1;
      end
      dl = sat_add(deadline_t'(delay), ms_count);
      // new timer goes behind every entry with a deadline not later than its own
      pos = list_len;
      while (pos > 0 && list_dl[pos-1] > dl) begin
        list_dl[pos] = list_dl[pos-1];
        list_id[pos] = list_id[pos-1];
        pos--;
      end
      list_dl[pos] = dl;
      list_id[pos] = id;
      list_len++;
      ev.kind = KIND_ACCEPTED;
      return;
    end
    if (!running || list_len == 0) return;
    ms_count = sat_add(ms_count, deadline_t'(1));
    if (list_dl[0] > ms_count) return;
    has_event = 1'b1;
    ev.kind = KIND_EXPIRED;
    ev.id = list_id[0];
    for (int i = 1; i < list_len; i++) begin
      list_dl[i-1] = list_dl[i];
      list_id[i-1] = list_id[i];
    end
    list_len--;
    if (list_len == 0) begin
      ms_count = '0;
      running = 1'b0;
    end
  endfunction

  // Called at a falling edge; returns at the falling edge after the accept.
  task automatic send_request(input logic op, input timer_id_t id,
                              input logic [DELAY_W-1:0] delay, input dir_row_t row);
    bit           has_event;
    timer_event_t ev;
    in_valid <= 1'b1;
    in_operation <= op;
    in_timer_id <= id;
    in_delay_ms <= delay;
    do @(posedge clk); while (!in_ready);
    predict_event(op, id, delay, has_event, ev);
    if (row.typed) begin
      has_event = row.has_event;
      ev.kind = row.kind;
      ev.id = row.event_id;
    end
    if (has_event) pending_events.push_back(ev);
    n_requests++;
    @(negedge clk);
  endtask

  task automatic hold_off(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_events.size() != 0);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      case (out_event_kind)
        KIND_ACCEPTED: n_accepted++;
        KIND_FULL:     n_full++;
        KIND_EXPIRED:  n_expired++;
        default: ;
      endcase
      if (pending_events.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected event: kind %0d id %02h", out_event_kind, out_event_id);
      end else begin
        if (out_event_kind !== pending_events[0].kind ||
            out_event_id !== pending_events[0].id) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: kind exp %0d got %0d, id exp %02h got %02h",
                     pending_events[0].kind, out_event_kind,
                     pending_events[0].id, out_event_id);
        end
        void'(pending_events.pop_front());
      end
    end
  end

  // result side backpressure
  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (!no_idle && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 25)) @(negedge clk);
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("[timer_deadline_queue] ERROR");
    $finish;
  end

  initial begin
    logic               op;
    timer_id_t          id;
    logic [DELAY_W-1:0] delay;
    int                 fill_left;
    int                 pick;

    rst_n = 1'b0;
    in_valid = 1'b0;
    in_operation = OP_ADD;
    in_timer_id = '0;
    in_delay_ms = '0;
    errors = 0;
    n_requests = 0;
    n_accepted = 0;
    n_full = 0;
    n_expired = 0;
    no_idle = 1'b0;
    list_len = 0;
    ms_count = '0;
    running = 1'b0;
    fill_left = 0;

    dir_rows = '{
      // tick while idle, zero delay, idle again with junk in unused fields
      '{OP_TICK, 8'h00, 22'd0,     1'b1, 1'b0, KIND_ACCEPTED, 8'h00},
      '{OP_ADD,  8'h00, 22'd0,     1'b1, 1'b1, KIND_ACCEPTED, 8'h00},
      '{OP_TICK, 8'h00, 22'd0,     1'b1, 1'b1, KIND_EXPIRED,  8'h00},
      '{OP_TICK, 8'h5A, DELAY_MAX, 1'b1, 1'b0, KIND_ACCEPTED, 8'h00},
      // fill the queue; repeated deadlines check arrival order
      '{OP_ADD,  8'h01, 22'd3,     1'b0, 1'b0, KIND_ACCEPTED, 8'h00},
      '{OP_ADD,  8'h02, 22'd1,     1'b0, 1'b0, KIND_ACCEPTED, 8'h00},
      '{OP_ADD,  8'h03, 22'd2,     1'b0, 1'b0, KIND_ACCEPTED, 8'h00},
      '{OP_ADD,  8'h04, 22'd1,     1'b0, 1'b0, KIND_ACCEPTED, 8'h00},
      '{OP_ADD,  8'h05, 22'd0,     1'b0, 1'b0, KIND_ACCEPTED, 8'h00},
      '{OP_ADD,  8'h06, 22'd5,     1'b0, 1'b0, KIND_ACCEPTED, 8'h00},
      '{OP_ADD,  8'h07, 22'd2,     1'b0, 1'b0, KIND_ACCEPTED, 8'h00},
      '{OP_ADD,  8'h08, 22'd0,     1'b0, 1'b0, KIND_ACCEPTED, 8'h00},
      '{OP_ADD,  8'h09, 22'd7,     1'b0, 1'b0, KIND_ACCEPTED, 8'h00},
      '{OP_ADD,  8'h0A, 22'd1,     1'b0, 1'b0, KIND_ACCEPTED, 8'h00},
      '{OP_ADD,  8'h0B, 22'd3,     1'b0, 1'b0, KIND_ACCEPTED, 8'h00},
      '{OP_ADD,  8'h0C, 22'd3,     1'b0, 1'b0, KIND_ACCEPTED, 8'h00},
      '{OP_ADD,  8'h0D, 22'd4,     1'b0, 1'b0, KIND_ACCEPTED, 8'h00},
      '{OP_ADD,  8'h0E, 22'd0,     1'b0, 1'b0, KIND_ACCEPTED, 8'h00},
      '{OP_ADD,  8'h0F, 22'd6,     1'b0, 1'b0, KIND_ACCEPTED, 8'h00},
      '{OP_ADD,  8'h10, 22'd2,     1'b0, 1'b0, KIND_ACCEPTED, 8'h00},
      // queue full, largest delay
      '{OP_ADD,  8'hFF, DELAY_MAX, 1'b1, 1'b1, KIND_FULL,     8'hFF},
      '{OP_TICK, 8'hA5, 22'd0,     1'b0, 1'b0, KIND_ACCEPTED, 8'h00},
      '{OP_TICK, 8'h00, 22'd0,     1'b0, 1'b0, KIND_ACCEPTED, 8'h00},
      '{OP_TICK, 8'h00, 22'd0,     1'b0, 1'b0, KIND_ACCEPTED, 8'h00}
    };

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int r = 0; r < N_ROWS; r++) begin
      send_request(dir_rows[r].op, dir_rows[r].id, dir_rows[r].delay, dir_rows[r]);
      if ($urandom_range(0, 3) == 0) hold_off($urandom_range(1, 19));
    end
    wait_drained();

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 120 == 10) fill_left = DEPTH + 4;
      if (i == N_RANDOM / 2) wait_drained();
      if (i == N_RANDOM - N_TAIL) no_idle = 1'b1;
      if (fill_left > 0) begin
        op = OP_ADD;
        fill_left--;
      end else begin
        op = ($urandom_range(0, 9) < 6) ? OP_TICK : OP_ADD;
      end
      id = timer_id_t'($urandom_range(0, 255));
      pick = $urandom_range(0, 19);
      if (op == OP_TICK || list_len >= DEPTH)
        delay = DELAY_W'($urandom);  // unused or rejected: any value
      else if (pick < 14)
        delay = DELAY_W'($urandom_range(0, 8));
      else if (pick < 19)
        delay = DELAY_W'($urandom_range(0, 40));
      else
        delay = DELAY_W'($urandom_range(0, 300));
      send_request(op, id, delay, '0);
      if (!no_idle && $urandom_range(0, 5) == 0) hold_off($urandom_range(1, 19));
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (pending_events.size() != 0) begin
      errors++;
      $display("%0d expected events never arrived", pending_events.size());
    end
    $display("%0d requests sent: %0d adds taken, %0d refused as full, %0d timers expired",
             n_requests, n_accepted, n_full, n_expired);
    $display("covered idle ticks, zero delays, equal deadlines and a full queue");
    if (errors == 0) begin
      $display("[timer_deadline_queue] OK");
    end else begin
      $display("%0d failures", errors);
      $display("[timer_deadline_queue] ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/tdq_pkg.sv
design/tdq_cell.sv
design/timer_deadline_queue.sv
bench/testbench.sv
